FILE: rtl/assert_macros.svh
// Assertion macros for the RTL, included by triangle_face_normal.sv.
// Synthesis builds define SYNTH, which turns every macro into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/tfn_pkg.sv
package tfn_pkg;

    // Default geometry of the datapath.
    localparam int COORD_BITS_DEF       = 32;
    localparam int NORMAL_FRAC_BITS_DEF = 15;

    // Fixed field widths of the stream items.
    localparam int TAG_W    = 16;
    localparam int NORMAL_W = 16;

    // Width of the signed intermediate used to apply the sign to a normal.
    localparam int SIGNED_W = 32;

endpackage

FILE: rtl/tfn_mult.sv
// Unsigned multiplier split into four half-width partial products.
// Stage one forms the partial products, stage two adds them.
module tfn_mult #(
    parameter int WA = 32
) (
    input  logic            clk,
    input  logic            en,
    input  logic [WA-1:0]   a,
    input  logic [WA-1:0]   b,
    output logic [2*WA-1:0] p
);

    localparam int LW = WA / 2;
    localparam int HW = WA - LW;

    logic [2*LW-1:0]  pp_ll_reg;
    logic [WA-1:0]    pp_lh_reg;
    logic [WA-1:0]    pp_hl_reg;
    logic [2*HW-1:0]  pp_hh_reg;
    logic [2*WA-1:0]  p_reg;
    logic [2*WA-1:0]  p_next;

    // Partial products of the low and high halves.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= a[LW-1:0] * b[LW-1:0];
            pp_lh_reg <= a[LW-1:0] * b[WA-1:LW];
            pp_hl_reg <= a[WA-1:LW] * b[LW-1:0];
            pp_hh_reg <= a[WA-1:LW] * b[WA-1:LW];
        end
    end

    // Aligned sum of the partial products.
    always_comb
    begin
        p_next = {{(2*HW){1'b0}}, pp_ll_reg}
               + ({{WA{1'b0}}, pp_lh_reg} << LW)
               + ({{WA{1'b0}}, pp_hl_reg} << LW)
               + ({{(2*LW){1'b0}}, pp_hh_reg} << (2*LW));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

FILE: rtl/tfn_cross.sv
// Edge vectors and their exact cross product, as magnitude and sign.
// Seven register stages: edges, edge magnitudes, two multiplier stages,
// signed products, difference, and the magnitude of the result.
module tfn_cross #(
    parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [COORD_BITS-1:0] a [3],
    input  logic [COORD_BITS-1:0] b [3],
    input  logic [COORD_BITS-1:0] c [3],
    output logic [2*COORD_BITS:0] n_mag [3],
    output logic [2:0]            n_neg
);

    localparam int CW = COORD_BITS;
    localparam int PW = 2 * CW;
    localparam int NW = 2 * CW + 1;

    logic [CW:0]   e1_reg [3];
    logic [CW:0]   e2_reg [3];
    logic [CW:0]   e1_abs [3];
    logic [CW:0]   e2_abs [3];
    logic [CW-1:0] m1_reg [3];
    logic [CW-1:0] m2_reg [3];
    logic [2:0]    s1_reg;
    logic [2:0]    s2_reg;
    logic [PW-1:0] p_prod [3];
    logic [PW-1:0] q_prod [3];
    logic [2:0]    pn_d1_reg;
    logic [2:0]    qn_d1_reg;
    logic [2:0]    pn_d2_reg;
    logic [2:0]    qn_d2_reg;
    logic [NW-1:0] ps_reg [3];
    logic [NW-1:0] qs_reg [3];
    logic [NW:0]   n_reg [3];
    logic [NW:0]   n_abs [3];
    logic [NW-1:0] nmag_reg [3];
    logic [2:0]    nneg_reg;

    // Edges from the first vertex, one bit wider than a coordinate.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k] <= {b[k][CW-1], b[k]} - {a[k][CW-1], a[k]};
                e2_reg[k] <= {c[k][CW-1], c[k]} - {a[k][CW-1], a[k]};
            end
        end
    end

    // Edge magnitudes and signs.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1_abs[k] = e1_reg[k][CW] ? (~e1_reg[k] + 1'b1) : e1_reg[k];
            e2_abs[k] = e2_reg[k][CW] ? (~e2_reg[k] + 1'b1) : e2_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                m1_reg[k] <= e1_abs[k][CW-1:0];
                m2_reg[k] <= e2_abs[k][CW-1:0];
                s1_reg[k] <= e1_reg[k][CW];
                s2_reg[k] <= e2_reg[k][CW];
            end
        end
    end

    // Both edge products of each cross product component.
    for (genvar k = 0; k < 3; k++)
    begin : g_prod
        localparam int U = (k + 1) % 3;
        localparam int V = (k + 2) % 3;

        tfn_mult #(
            .WA (CW)
        ) u_mult_p (
            .clk (clk),
            .en  (en),
            .a   (m1_reg[U]),
            .b   (m2_reg[V]),
            .p   (p_prod[k])
        );

        tfn_mult #(
            .WA (CW)
        ) u_mult_q (
            .clk (clk),
            .en  (en),
            .a   (m1_reg[V]),
            .b   (m2_reg[U]),
            .p   (q_prod[k])
        );
    end

    // The product signs ride alongside the multipliers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pn_d1_reg[k] <= s1_reg[(k + 1) % 3] ^ s2_reg[(k + 2) % 3];
                qn_d1_reg[k] <= s1_reg[(k + 2) % 3] ^ s2_reg[(k + 1) % 3];
                pn_d2_reg[k] <= pn_d1_reg[k];
                qn_d2_reg[k] <= qn_d1_reg[k];
            end
        end
    end

    // Signed products, then their difference.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ps_reg[k] <= pn_d2_reg[k] ? (~{1'b0, p_prod[k]} + 1'b1) : {1'b0, p_prod[k]};
                qs_reg[k] <= qn_d2_reg[k] ? (~{1'b0, q_prod[k]} + 1'b1) : {1'b0, q_prod[k]};
                n_reg[k]  <= {ps_reg[k][NW-1], ps_reg[k]} - {qs_reg[k][NW-1], qs_reg[k]};
            end
        end
    end

    // Magnitude and sign of each cross product component.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            n_abs[k] = n_reg[k][NW] ? (~n_reg[k] + 1'b1) : n_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                nmag_reg[k] <= n_abs[k][NW-1:0];
                nneg_reg[k] <= n_reg[k][NW];
            end
        end
    end

    assign n_mag = nmag_reg;
    assign n_neg = nneg_reg;

endmodule

FILE: rtl/tfn_root.sv
// Exact quotient |N| * 2^F / sqrt(S), one result bit per register stage.
// R holds T - m*m*S and P holds m*S, so each bit costs one add and compare:
// bit b is kept when R >= (P << (b+1)) + (S << 2b).
module tfn_root #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic [4*COORD_BITS+3:0]                  s_at [NORMAL_FRAC_BITS+1],
    input  logic [4*COORD_BITS+2*NORMAL_FRAC_BITS+7:0] t,
    output logic [NORMAL_FRAC_BITS:0]                m
);

    localparam int F     = NORMAL_FRAC_BITS;
    localparam int SW    = 4 * COORD_BITS + 4;
    localparam int W     = 4 * COORD_BITS + 2 * F + 8;
    localparam int NSTEP = F + 1;

    logic [W-1:0] r_reg [NSTEP];
    logic [W-1:0] p_reg [NSTEP];
    logic [F:0]   m_reg [NSTEP];

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_step
        localparam int B = F - i;

        logic [W-1:0] r_in;
        logic [W-1:0] p_in;
        logic [F:0]   m_in;
        logic [W-1:0] s_ext;
        logic [W-1:0] d;
        logic         take;

        // Previous stage, or the start values R = T, P = 0, m = 0.
        if (i == 0)
        begin : g_first
            assign r_in = t;
            assign p_in = '0;
            assign m_in = '0;
        end
        else
        begin : g_next
            assign r_in = r_reg[i-1];
            assign p_in = p_reg[i-1];
            assign m_in = m_reg[i-1];
        end

        // Trial of bit B.
        always_comb
        begin
            s_ext = {{(W-SW){1'b0}}, s_at[i]};
            d     = (p_in << (B + 1)) + (s_ext << (2 * B));
            take  = (r_in >= d);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i] <= take ? (r_in - d) : r_in;
                p_reg[i] <= take ? (p_in + (s_ext << B)) : p_in;
                m_reg[i] <= take ? (m_in | ({{F{1'b0}}, 1'b1} << B)) : m_in;
            end
        end
    end

    assign m = m_reg[NSTEP-1];

endmodule

FILE: rtl/tfn_norm.sv
// Squared length of the cross product and the three quotient lanes.
// Two multiplier stages, one stage for the sum, then F+1 quotient stages.
module tfn_norm #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [2*COORD_BITS:0]     n_mag [3],
    input  logic [2:0]                n_neg,
    output logic [NORMAL_FRAC_BITS:0] q_mag [3],
    output logic [2:0]                q_neg,
    output logic                      zero
);

    localparam int F     = NORMAL_FRAC_BITS;
    localparam int NW    = 2 * COORD_BITS + 1;
    localparam int QW    = 2 * NW;
    localparam int SW    = QW + 2;
    localparam int W     = 4 * COORD_BITS + 2 * F + 8;
    localparam int NSTEP = F + 1;

    logic [QW-1:0] sq [3];
    logic [2:0]    sg1_reg;
    logic [2:0]    sg2_reg;
    logic [2:0]    sg3_reg;
    logic          zero_reg;
    logic [SW-1:0] s_reg;
    logic [W-1:0]  t_reg [3];
    logic [SW-1:0] s_dly_reg [NSTEP-1];
    logic [SW-1:0] s_at [NSTEP];
    logic [2:0]    sgr_reg [NSTEP];
    logic          zr_reg [NSTEP];

    // Squares of the three components.
    for (genvar k = 0; k < 3; k++)
    begin : g_sq
        tfn_mult #(
            .WA (NW)
        ) u_mult_sq (
            .clk (clk),
            .en  (en),
            .a   (n_mag[k]),
            .b   (n_mag[k]),
            .p   (sq[k])
        );
    end

    // Sum of squares, scaled squares of the components, zero-vector flag, delayed signs.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sg1_reg  <= n_neg;
            sg2_reg  <= sg1_reg;
            sg3_reg  <= sg2_reg;
            s_reg    <= {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
            zero_reg <= ~|{sq[0], sq[1], sq[2]};
            for (int k = 0; k < 3; k++)
            begin
                t_reg[k] <= {{(W-QW-2*F){1'b0}}, sq[k], {(2*F){1'b0}}};
            end
        end
    end

    // The sum travels beside the lanes so each stage sees its own item.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_dly_reg[0] <= s_reg;
            for (int i = 1; i < NSTEP - 1; i++)
            begin
                s_dly_reg[i] <= s_dly_reg[i-1];
            end
        end
    end

    always_comb
    begin
        s_at[0] = s_reg;
        for (int i = 1; i < NSTEP; i++)
        begin
            s_at[i] = s_dly_reg[i-1];
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        tfn_root #(
            .COORD_BITS       (COORD_BITS),
            .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
        ) u_root (
            .clk  (clk),
            .en   (en),
            .s_at (s_at),
            .t    (t_reg[k]),
            .m    (q_mag[k])
        );
    end

    // Signs and the zero flag keep pace with the lanes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sgr_reg[0] <= sg3_reg;
            zr_reg[0]  <= zero_reg;
            for (int i = 1; i < NSTEP; i++)
            begin
                sgr_reg[i] <= sgr_reg[i-1];
                zr_reg[i]  <= zr_reg[i-1];
            end
        end
    end

    assign q_neg = sgr_reg[NSTEP-1];
    assign zero  = zr_reg[NSTEP-1];

endmodule

FILE: rtl/triangle_face_normal.sv
// Channel | Direction | Payload
// s_*     | in        | triangle: tag and three vertices
// m_*     | out       | tag and unit normal, degenerate flag in tuser
//
// One item enters per cycle unless the output stalls; the quotient lanes
// produce one result bit per stage.
// Reset clears only the valid bits; data registers load freely.
// A stall at the output freezes the whole pipeline, bubbles included,
// so s_tready follows !m_tvalid || m_tready.
`include "assert_macros.svh"

module triangle_face_normal #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF,
    localparam int IN_BITS    = tfn_pkg::TAG_W + 9 * COORD_BITS,
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // triangle_index, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero pad
    input  logic [IN_TDATA_W-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tag_out, normal_x, normal_y, normal_z
    output logic [63:0]           m_tdata,
    // degenerate
    output logic                  m_tuser
);

    localparam int CW    = COORD_BITS;
    localparam int F     = NORMAL_FRAC_BITS;
    localparam int TW    = tfn_pkg::TAG_W;
    localparam int OW    = tfn_pkg::NORMAL_W;
    localparam int XW    = tfn_pkg::SIGNED_W;
    localparam int PIPE  = F + 11;

    logic          adv;
    logic [CW-1:0] va [3];
    logic [CW-1:0] vb [3];
    logic [CW-1:0] vc [3];
    logic [2*CW:0] n_mag [3];
    logic [2:0]    n_neg;
    logic [F:0]    q_mag [3];
    logic [2:0]    q_neg;
    logic          q_zero;
    logic [PIPE-1:0] vld_reg;
    logic [TW-1:0] tag_reg [PIPE];
    logic [F:0]    mag_sat [3];
    logic [XW-1:0] sval [3];
    logic [OW-1:0] nrm_next [3];
    logic          out_vld_reg;
    logic [63:0]   out_data_reg;
    logic          out_deg_reg;

    // The pipeline moves whenever the output register can take an item.
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    // Unpack the vertices.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            va[k] = s_tdata[TW + k * CW +: CW];
            vb[k] = s_tdata[TW + (k + 3) * CW +: CW];
            vc[k] = s_tdata[TW + (k + 6) * CW +: CW];
        end
    end

    tfn_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk   (clk),
        .en    (adv),
        .a     (va),
        .b     (vb),
        .c     (vc),
        .n_mag (n_mag),
        .n_neg (n_neg)
    );

    tfn_norm #(
        .COORD_BITS       (COORD_BITS),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_norm (
        .clk   (clk),
        .en    (adv),
        .n_mag (n_mag),
        .n_neg (n_neg),
        .q_mag (q_mag),
        .q_neg (q_neg),
        .zero  (q_zero)
    );

    // Valid bits beside the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[PIPE-2:0], s_tvalid};
            out_vld_reg <= vld_reg[PIPE-1];
        end
    end

    // Tags beside the datapath.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[0] <= s_tdata[TW-1:0];
            for (int i = 1; i < PIPE; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // Saturate an exact 1.0, apply the sign, clear on a zero vector.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_sat[k]  = (q_mag[k] > {1'b0, {F{1'b1}}}) ? {1'b0, {F{1'b1}}} : q_mag[k];
            sval[k]     = {{(XW-F-1){1'b0}}, mag_sat[k]};
            if (q_zero)
            begin
                sval[k] = '0;
            end
            else if (q_neg[k])
            begin
                sval[k] = ~sval[k] + 1'b1;
            end
            nrm_next[k] = sval[k][OW-1:0];
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {nrm_next[2], nrm_next[1], nrm_next[0], tag_reg[PIPE-1]};
            out_deg_reg  <= q_zero;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_deg_reg;

    // A degenerate triangle has an all-zero normal.
    `ASSERT_IMPL(a_degen_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata[63:16] == '0, "degenerate item with nonzero normal")
    // A proper unit normal always has some nonzero component.
    `ASSERT_IMPL(a_unit_nonzero, clk, rst_n, m_tvalid && !m_tuser, m_tdata[63:16] != '0, "nondegenerate item with zero normal")

endmodule
